/* rtl/tracker_pattern_cell_parser_assert.svh */
// Assertion macros for the tracker pattern cell parser.
`ifndef TRACKER_PATTERN_CELL_PARSER_ASSERT_SVH
`define TRACKER_PATTERN_CELL_PARSER_ASSERT_SVH

`ifndef SYNTHESIS
`define TPCP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("tpcp check failed");
`define TPCP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("tpcp check failed");
`else
`define TPCP_ASSERT(lbl, prop)
`define TPCP_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

/* rtl/tpcp_pkg.sv */
// Types and constants shared by the pattern cell parser modules.
package tpcp_pkg;

  localparam logic [4:0] FLD_NOTE       = 5'h01;
  localparam logic [4:0] FLD_INSTRUMENT = 5'h02;
  localparam logic [4:0] FLD_VOLUME     = 5'h04;
  localparam logic [4:0] FLD_EFFECT     = 5'h08;
  localparam logic [4:0] FLD_PARAM      = 5'h10;
  localparam logic [4:0] FLD_AFTER_NOTE = 5'h1e;

  localparam logic [7:0] NOTE_OFF_STORED = 8'd97;
  localparam logic [7:0] NOTE_OFFSET     = 8'd11;
  localparam logic [7:0] EFF_SET_VOLUME  = 8'd12;
  localparam logic [7:0] EFF_KEY_OFF     = 8'd20;
  localparam logic [7:0] VOL_MAX         = 8'd63;

  localparam logic [7:0] VCOL_SET_LO   = 8'h10;
  localparam logic [7:0] VCOL_SET_TOP  = 8'h50;
  localparam logic [7:0] VCOL_SLIDE_LO = 8'h60;
  localparam logic [7:0] VCOL_SLIDE_HI = 8'h9f;
  localparam logic [7:0] VCOL_VIB_LO   = 8'ha0;
  localparam logic [7:0] VCOL_PORTA_HI = 8'hbf;
  localparam logic [7:0] VCOL_HIGH_LO  = 8'hf0;
  localparam logic [7:0] VCOL_SHIFT_UP = 8'h10;
  localparam logic [7:0] VCOL_SLIDE_DN = 8'h20;
  localparam logic [7:0] VCOL_HIGH_DN  = 8'h50;

  localparam logic REG_CHANNEL_COUNT = 1'b0;
  localparam logic REG_NOTE_OFF_CODE = 1'b1;

  localparam logic [5:0] CHANNEL_COUNT_RESET = 6'd4;
  localparam logic [7:0] NOTE_OFF_RESET      = 8'd254;

  typedef struct packed {
    logic [4:0] channel;
    logic       last;
    logic [7:0] note;
    logic [7:0] instrument;
    logic [7:0] volume;
    logic [7:0] effect;
    logic [7:0] param;
  } cell_rec_t;

  typedef struct packed {
    logic [4:0] channel;
    logic       last_in_row;
    logic       note_valid;
    logic [7:0] note;
    logic       instrument_valid;
    logic [7:0] instrument;
    logic       volume_valid;
    logic [7:0] volume;
    logic [7:0] effect;
    logic [7:0] effect_param;
  } out_cell_t;

endpackage

/* rtl/tracker_pattern_cell_parser.sv */
// Top level: packed pattern byte stream in, one mapped channel cell per completed cell out.
// A completed cell goes through the two-entry queue, then the output register to m_tvalid.
// Throughput: one byte per cycle; the parser, the two-entry queue and the output register
// each move one word a cycle, so the rate holds while m_tready stays high.
// Reset (synchronous): parse state, channel counter, queue and output valid clear;
// channel_count returns to 4 and note_off_code to 254.
module tracker_pattern_cell_parser
  import tpcp_pkg::*;
#(
  parameter int MAX_CHANNELS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  input  logic        s_tuser,   // pattern_start
  output logic        m_tvalid,
  input  logic        m_tready,
  // channel[4:0], note_valid[5], note[13:6], instrument_valid[14], instrument[22:15],
  // volume_valid[23], volume[31:24], effect[39:32], effect_param[47:40]
  output logic [47:0] m_tdata,
  output logic        m_tlast,   // last_in_row
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [5:0] channel_count;
  logic [7:0] note_off_code;
  logic       cfg_write;

  logic       push;
  cell_rec_t  push_rec;
  logic       q_full;
  logic       q_not_empty;
  logic       q_pop;
  cell_rec_t  q_head;
  out_cell_t  out_cell;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_NOTE_OFF_CODE) ? {24'd0, note_off_code}
                                                     : {26'd0, channel_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= CHANNEL_COUNT_RESET;
      note_off_code <= NOTE_OFF_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_CHANNEL_COUNT) begin
        channel_count <= pwdata[5:0];
      end else begin
        note_off_code <= pwdata[7:0];
      end
    end
  end

  tpcp_front #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .data_byte    (s_tdata),
    .pattern_start(s_tuser),
    .channel_count(channel_count),
    .queue_full   (q_full),
    .push         (push),
    .rec          (push_rec)
  );

  tpcp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .full     (q_full),
    .not_empty(q_not_empty),
    .pop      (q_pop),
    .head     (q_head)
  );

  tpcp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .note_off_code(note_off_code),
    .rec_valid    (q_not_empty),
    .rec          (q_head),
    .pop          (q_pop),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_cell     (out_cell)
  );

  assign m_tlast = out_cell.last_in_row;
  assign m_tdata = {out_cell.effect_param, out_cell.effect, out_cell.volume,
                    out_cell.volume_valid, out_cell.instrument, out_cell.instrument_valid,
                    out_cell.note, out_cell.note_valid, out_cell.channel};

endmodule

/* rtl/tpcp_front.sv */
// Byte parser: tracks the presence mask, gathers cell bytes, counts channels.
module tpcp_front
  import tpcp_pkg::*;
#(
  parameter int MAX_CHANNELS = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       pattern_start,
  input  logic [5:0] channel_count,
  input  logic       queue_full,
  output logic       push,
  output cell_rec_t  rec
);

  localparam int CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic [4:0]    mask, mask_next;
  logic [CW-1:0] counter, counter_next;
  logic [7:0]    note, note_next;
  logic [7:0]    instrument, instrument_next;
  logic [7:0]    volume, volume_next;
  logic [7:0]    effect, effect_next;

  logic          accept;
  logic [4:0]    mask_cur;
  logic [4:0]    lowest;
  logic [CW-1:0] counter_cur;
  logic [7:0]    cnt_eff;
  logic [7:0]    cnt_plus;
  logic          last;
  logic [CW+4:0] chan_ext;
  logic [7:0]    param;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    mask_cur    = pattern_start ? 5'd0 : mask;
    counter_cur = pattern_start ? '0 : counter;
    lowest      = mask_cur & (~mask_cur + 5'd1);

    if (channel_count == 6'd0) begin
      cnt_eff = 8'd1;
    end else if ({2'b00, channel_count} > 8'(MAX_CHANNELS)) begin
      cnt_eff = 8'(MAX_CHANNELS);
    end else begin
      cnt_eff = {2'b00, channel_count};
    end
    cnt_plus = 8'(counter_cur) + 8'd1;
    last     = cnt_plus >= cnt_eff;
    chan_ext = {5'd0, counter_cur};

    mask_next       = mask;
    counter_next    = counter;
    note_next       = note;
    instrument_next = instrument;
    volume_next     = volume;
    effect_next     = effect;
    param           = 8'd0;
    push            = 1'b0;

    if (accept) begin
      counter_next = counter_cur;
      if (mask_cur == 5'd0) begin
        note_next       = 8'd0;
        instrument_next = 8'd0;
        volume_next     = 8'd0;
        effect_next     = 8'd0;
        if (data_byte[7]) begin
          mask_next = data_byte[4:0];
          push      = (data_byte[4:0] == 5'd0);
        end else begin
          note_next = data_byte;
          mask_next = FLD_AFTER_NOTE;
        end
      end else begin
        mask_next = mask_cur & ~lowest;
        case (lowest)
          FLD_NOTE: begin
            note_next = data_byte;
          end
          FLD_INSTRUMENT: begin
            instrument_next = data_byte;
          end
          FLD_VOLUME: begin
            volume_next = data_byte;
          end
          FLD_EFFECT: begin
            effect_next = data_byte;
          end
          default: begin
            param     = data_byte;
            mask_next = 5'd0;
          end
        endcase
        push = (mask_next == 5'd0);
      end
      if (push) begin
        counter_next = last ? '0 : CW'(cnt_plus);
      end
    end

    rec.channel    = chan_ext[4:0];
    rec.last       = last;
    rec.note       = note_next;
    rec.instrument = instrument_next;
    rec.volume     = volume_next;
    rec.effect     = effect_next;
    rec.param      = param;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask    <= 5'd0;
      counter <= '0;
    end else begin
      mask    <= mask_next;
      counter <= counter_next;
    end
    note       <= note_next;
    instrument <= instrument_next;
    volume     <= volume_next;
    effect     <= effect_next;
  end

endmodule

/* rtl/tpcp_queue.sv */
// Two-entry queue of completed cells between parser and mapper.
module tpcp_queue
  import tpcp_pkg::*;
`include "tracker_pattern_cell_parser_assert.svh"
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  cell_rec_t push_rec,
  output logic      full,
  output logic      not_empty,
  input  logic      pop,
  output cell_rec_t head
);

  cell_rec_t  entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
    if (push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  `TPCP_ASSERT(a_count_bound, count <= 2'd2)
  `TPCP_ASSERT(a_no_push_full, push |-> !full)
  `TPCP_ASSERT(a_no_pop_empty, pop |-> not_empty)
  `TPCP_ASSERT(a_push_grows, (push && !pop) |=> (count == $past(count) + 2'd1))

endmodule

/* rtl/tpcp_back.sv */
// Cell mapper: remaps note, instrument and volume column into the output register.
module tpcp_back
  import tpcp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] note_off_code,
  input  logic       rec_valid,
  input  cell_rec_t  rec,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output out_cell_t  out_cell
);

  out_cell_t mapped;
  logic [7:0] v;

  assign pop = rec_valid && (!out_valid || out_ready);

  always_comb begin
    v = rec.volume;
    mapped.channel      = rec.channel;
    mapped.last_in_row  = rec.last;
    mapped.effect       = rec.effect;
    mapped.effect_param = rec.param;

    mapped.note_valid = (rec.note != 8'd0);
    if (rec.note == 8'd0) begin
      mapped.note = 8'd0;
    end else if (rec.note == NOTE_OFF_STORED) begin
      mapped.note = note_off_code;
    end else begin
      mapped.note = rec.note + NOTE_OFFSET;
    end

    mapped.instrument_valid = (rec.instrument != 8'd0);
    mapped.instrument = (rec.instrument != 8'd0) ? rec.instrument - 8'd1 : 8'd0;

    mapped.volume_valid = 1'b1;
    if (v >= VCOL_SET_LO && v < VCOL_SET_TOP) begin
      mapped.volume = v - VCOL_SET_LO;
    end else if (v == VCOL_SET_TOP) begin
      mapped.volume = VOL_MAX;
    end else if (v >= VCOL_SLIDE_LO && v <= VCOL_SLIDE_HI) begin
      mapped.volume = v - VCOL_SLIDE_DN;
    end else if (v >= VCOL_VIB_LO && v <= VCOL_PORTA_HI) begin
      mapped.volume = v + VCOL_SHIFT_UP;
    end else if (v >= VCOL_HIGH_LO) begin
      mapped.volume = v - VCOL_HIGH_DN;
    end else begin
      mapped.volume_valid = 1'b0;
      mapped.volume       = 8'd0;
    end

    if (rec.effect == EFF_SET_VOLUME) begin
      mapped.volume_valid = 1'b1;
      mapped.volume       = (rec.param > VOL_MAX) ? VOL_MAX : rec.param;
    end else if (rec.effect == EFF_KEY_OFF) begin
      mapped.note_valid = 1'b1;
      mapped.note       = note_off_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (pop) begin
      out_cell <= mapped;
    end
  end

endmodule

/* bench/tb_tracker_pattern_cell_parser.sv */
// Self-checking testbench for the tracker pattern cell parser: streamed bytes in, checked cells out.
`timescale 1ns / 1ps

module tb_tracker_pattern_cell_parser;
  import tpcp_pkg::*;

  localparam int MAX_CELLS = 32;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_COUNT = 9;
  localparam int PHASE_BYTES = 203;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } stream_byte_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;    // data_byte
  logic        s_tuser = 1'b0;     // pattern_start
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // channel[4:0], note_valid[5], note[13:6], instrument_valid[14], instrument[22:15],
  // volume_valid[23], volume[31:24], effect[39:32], effect_param[47:40]
  logic [47:0] m_tdata;
  logic        m_tlast;            // last_in_row
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  tracker_pattern_cell_parser #(
    .MAX_CHANNELS(MAX_CELLS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  stream_byte_t pattern_bytes[$];
  out_cell_t    pending_cells[$];

  int src_gap_pct = 10;
  int sink_stall_pct = 46;
  int errors = 0;
  int bytes_taken = 0;
  int cells_checked = 0;

  logic [5:0] cfg_channels = CHANNEL_COUNT_RESET;
  logic [7:0] cfg_note_off = NOTE_OFF_RESET;

  logic [4:0] field_mask;
  logic [7:0] cell_note;
  logic [7:0] cell_instrument;
  logic [7:0] cell_volume;
  logic [7:0] cell_effect;
  logic [4:0] chan_ctr;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic clear_parser();
    field_mask = '0;
    cell_note = '0;
    cell_instrument = '0;
    cell_volume = '0;
    cell_effect = '0;
    chan_ctr = '0;
  endtask

  task automatic close_cell(input logic [7:0] param);
    out_cell_t  c;
    logic [5:0] row_len;
    logic [7:0] v;
    row_len = (cfg_channels == 6'd0) ? 6'd1 :
              (cfg_channels > 6'(MAX_CELLS)) ? 6'(MAX_CELLS) : cfg_channels;
    v = cell_volume;
    c = '0;
    c.channel = chan_ctr;
    c.last_in_row = (6'(chan_ctr) + 6'd1) >= row_len;
    if (cell_note != 8'd0) begin
      c.note_valid = 1'b1;
      c.note = (cell_note == NOTE_OFF_STORED) ? cfg_note_off : cell_note + NOTE_OFFSET;
    end
    if (cell_instrument != 8'd0) begin
      c.instrument_valid = 1'b1;
      c.instrument = cell_instrument - 8'd1;
    end
    if (v >= VCOL_SET_LO && v <= VCOL_SET_TOP) begin
      c.volume_valid = 1'b1;
      c.volume = (v < VCOL_SET_TOP) ? v - VCOL_SET_LO : VOL_MAX;
    end else if (v >= VCOL_SLIDE_LO && v <= VCOL_SLIDE_HI) begin
      c.volume_valid = 1'b1;
      c.volume = v - VCOL_SLIDE_DN;
    end else if (v >= VCOL_VIB_LO && v <= VCOL_PORTA_HI) begin
      c.volume_valid = 1'b1;
      c.volume = v + VCOL_SHIFT_UP;
    end else if (v >= VCOL_HIGH_LO) begin
      c.volume_valid = 1'b1;
      c.volume = v - VCOL_HIGH_DN;
    end
    if (cell_effect == EFF_SET_VOLUME) begin
      c.volume_valid = 1'b1;
      c.volume = (param > VOL_MAX) ? VOL_MAX : param;
    end else if (cell_effect == EFF_KEY_OFF) begin
      c.note_valid = 1'b1;
      c.note = cfg_note_off;
    end
    c.effect = cell_effect;
    c.effect_param = param;
    pending_cells = {pending_cells, c};
    chan_ctr = c.last_in_row ? 5'd0 : chan_ctr + 5'd1;
    field_mask = '0;
  endtask

  task automatic take_pattern_byte(input logic [7:0] b, input logic start);
    logic [4:0] lowest;
    if (start)
      clear_parser();
    if (field_mask == 5'd0) begin
      cell_note = '0;
      cell_instrument = '0;
      cell_volume = '0;
      cell_effect = '0;
      if (b[7]) begin
        field_mask = b[4:0];
        if (field_mask == 5'd0)
          close_cell(8'd0);
      end else begin
        cell_note = b;
        field_mask = FLD_AFTER_NOTE;
      end
    end else begin
      lowest = field_mask & (~field_mask + 5'd1);
      field_mask = field_mask & ~lowest;
      case (lowest)
        FLD_NOTE:       cell_note = b;
        FLD_INSTRUMENT: cell_instrument = b;
        FLD_VOLUME:     cell_volume = b;
        FLD_EFFECT:     cell_effect = b;
        default:        close_cell(b);
      endcase
      if (lowest != FLD_PARAM && field_mask == 5'd0)
        close_cell(8'd0);
    end
  endtask

  always @(posedge clk) begin : byte_driver
    stream_byte_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= 8'h00;
      s_tuser <= 1'b0;
      cfg_channels = CHANNEL_COUNT_RESET;
      cfg_note_off = NOTE_OFF_RESET;
      clear_parser();
    end else begin
      if (s_tvalid && s_tready) begin
        take_pattern_byte(s_tdata, s_tuser);
        bytes_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (pattern_bytes.size() > 0 && $urandom_range(99) >= src_gap_pct) begin
          nxt = pattern_bytes.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= nxt.data;
          s_tuser <= nxt.start;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  function automatic string cell_text(input out_cell_t c);
    return $sformatf("ch=%0d last=%0d note=%0d/%0d ins=%0d/%0d vol=%0d/%0h eff=%0h par=%0h",
                     c.channel, c.last_in_row, c.note_valid, c.note, c.instrument_valid,
                     c.instrument, c.volume_valid, c.volume, c.effect, c.effect_param);
  endfunction

  always @(posedge clk) begin : cell_monitor
    out_cell_t got;
    out_cell_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.channel = m_tdata[4:0];
        got.last_in_row = m_tlast;
        got.note_valid = m_tdata[5];
        got.note = m_tdata[13:6];
        got.instrument_valid = m_tdata[14];
        got.instrument = m_tdata[22:15];
        got.volume_valid = m_tdata[23];
        got.volume = m_tdata[31:24];
        got.effect = m_tdata[39:32];
        got.effect_param = m_tdata[47:40];
        if (pending_cells.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("ERROR: unexpected cell %s", cell_text(got));
        end else begin
          want = pending_cells.pop_front();
          cells_checked++;
          if (got.channel !== want.channel || got.last_in_row !== want.last_in_row ||
              got.note_valid !== want.note_valid || got.note !== want.note ||
              got.instrument_valid !== want.instrument_valid ||
              got.instrument !== want.instrument || got.volume_valid !== want.volume_valid ||
              got.volume !== want.volume || got.effect !== want.effect ||
              got.effect_param !== want.effect_param) begin
            errors++;
            if (errors <= REPORT_LIMIT)
              $display("ERROR: cell mismatch\n  exp %s\n  got %s",
                       cell_text(want), cell_text(got));
          end
        end
      end
      m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  task automatic push_byte(input logic [7:0] data, input logic start);
    stream_byte_t sb;
    sb.data = data;
    sb.start = start;
    pattern_bytes = {pattern_bytes, sb};
  endtask

  task automatic reg_write(input logic reg_sel, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_sel, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (reg_sel == REG_CHANNEL_COUNT)
      cfg_channels = value[5:0];
    else
      cfg_note_off = value[7:0];
  endtask

  task automatic wait_drained();
    while (pattern_bytes.size() != 0 || s_tvalid || pending_cells.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] field_byte(input int kind);
    case (kind)
      0: case ($urandom_range(5))
           0: return 8'd0;
           1: return NOTE_OFF_STORED;
           2: return 8'($urandom_range(245, 255));
           3: return 8'($urandom_range(255));
           default: return 8'($urandom_range(1, 96));
         endcase
      1: case ($urandom_range(4))
           0: return 8'd0;
           1: return 8'd255;
           default: return 8'($urandom_range(255));
         endcase
      2: case ($urandom_range(7))
           0: return 8'($urandom_range(8'h0f));
           1: return 8'($urandom_range(8'h10, 8'h50));
           2: return $urandom_range(1) ? 8'($urandom_range(8'h51, 8'h5f))
                                       : 8'($urandom_range(8'hc0, 8'hef));
           3: return 8'($urandom_range(8'h60, 8'h9f));
           4: return 8'($urandom_range(8'ha0, 8'hbf));
           5: return 8'($urandom_range(8'hf0, 8'hff));
           default: return 8'($urandom_range(255));
         endcase
      3: case ($urandom_range(5))
           0: return EFF_SET_VOLUME;
           1: return EFF_KEY_OFF;
           2: return 8'd0;
           default: return 8'($urandom_range(255));
         endcase
      default: case ($urandom_range(5))
           0: return VOL_MAX;
           1: return VOL_MAX + 8'd1;
           default: return 8'($urandom_range(255));
         endcase
    endcase
  endfunction

  task automatic queue_random_cells(input int target);
    int         added;
    int         drop;
    logic       restart;
    logic       start;
    logic [7:0] lead;
    logic [7:0] body[$];
    added = 0;
    restart = 1'b0;
    while (added < target) begin
      if ($urandom_range(99) < 3) begin
        push_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
        added++;
      end else begin
        body.delete();
        if ($urandom_range(3) == 0) begin
          case ($urandom_range(5))
            0: lead = 8'd0;
            1: lead = NOTE_OFF_STORED;
            default: lead = 8'($urandom_range(127));
          endcase
          body = {body, lead};
          for (int k = 1; k < 5; k++)
            body = {body, field_byte(k)};
        end else begin
          if ($urandom_range(15) == 0)
            lead = 8'h80 | 8'($urandom_range(3) << 5);
          else
            lead = 8'h80 | 8'($urandom_range(127));
          body = {body, lead};
          for (int k = 0; k < 5; k++)
            if (lead[k])
              body = {body, field_byte(k)};
        end
        start = restart || ($urandom_range(39) == 0);
        restart = 1'b0;
        if (body.size() > 1 && $urandom_range(99) < 6) begin
          drop = $urandom_range(1, body.size() - 1);
          repeat (drop) void'(body.pop_back());
          restart = 1'($urandom_range(1));
        end
        foreach (body[i]) begin
          push_byte(body[i], (i == 0) ? start : 1'b0);
        end
        added += body.size();
      end
    end
  endtask

  initial begin : stimulus
    logic [5:0] counts[PHASE_COUNT];
    logic [7:0] offs[PHASE_COUNT];
    counts = '{6'd1, 6'd32, 6'd0, 6'd63, 6'd7, 6'($urandom_range(1, 32)), 6'd33,
               6'($urandom_range(63)), CHANNEL_COUNT_RESET};
    offs = '{8'h00, 8'hff, NOTE_OFF_STORED, 8'h80, 8'($urandom_range(255)),
             8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
             NOTE_OFF_RESET};

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    push_byte(8'h80, 1'b1);
    push_byte(8'h9f, 1'b0);
    push_byte(NOTE_OFF_STORED, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(VCOL_SET_TOP, 1'b0);
    push_byte(EFF_SET_VOLUME, 1'b0);
    push_byte(8'd40, 1'b0);
    push_byte(8'hff, 1'b0);
    push_byte(8'd250, 1'b0);
    push_byte(8'hff, 1'b0);
    push_byte(8'hff, 1'b0);
    push_byte(8'hff, 1'b0);
    push_byte(8'hff, 1'b0);
    push_byte(8'h7f, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(VCOL_SLIDE_HI, 1'b0);
    push_byte(EFF_KEY_OFF, 1'b0);
    push_byte(8'h55, 1'b0);
    push_byte(8'h90, 1'b0);
    push_byte(8'hff, 1'b0);
    push_byte(8'h83, 1'b0);
    push_byte(VCOL_SET_LO, 1'b0);
    push_byte(8'h80, 1'b1);
    wait_drained();

    for (int p = 0; p < PHASE_COUNT; p++) begin
      if (p < 3) begin
        src_gap_pct = 10;
        sink_stall_pct = 46;
      end else if (p < 6) begin
        src_gap_pct = 46;
        sink_stall_pct = 10;
      end else begin
        src_gap_pct = 0;
        sink_stall_pct = 0;
      end
      reg_write(REG_CHANNEL_COUNT, 32'(counts[p]));
      reg_write(REG_NOTE_OFF_CODE, 32'(offs[p]));
      queue_random_cells(PHASE_BYTES);
      wait_drained();
    end

    if (pending_cells.size() != 0) begin
      errors++;
      $display("ERROR: %0d cells never arrived", pending_cells.size());
    end
    $display("Covered %0d pattern bytes and %0d checked cells over %0d register settings,",
             bytes_taken, cells_checked, PHASE_COUNT + 1);
    $display("with idle and stall on both stream sides; %0d errors", errors);
    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
